FILE: src/prc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg
// Shared constants and helpers for the particle contact resolver.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int FRACTION_BITS_DEF   = 8;

  localparam int MASS_W  = 16;
  localparam int TS_W    = 16;
  localparam int E_W     = 9;
  localparam int PEN_W   = 16;
  localparam int DEN_W   = MASS_W + 1;
  localparam int RATIO_W = 17;

  localparam logic [TS_W-1:0]    TS_RESET   = 16'd1092;
  localparam logic [RATIO_W-1:0] RATIO_ONE  = 17'd65536;
  localparam logic [RATIO_W-1:0] RATIO_HALF = 17'd32768;

  // Register map.
  localparam int              ADDR_W         = 3;
  localparam logic [ADDR_W-1:0] ADDR_TIME_STEP = 3'd0;

  // Quotient bits resolved per pipeline stage after the first stage.
  localparam int DIV_STEPS = 4;

  // Impulse components are clamped to +-2^IMPULSE_EXP.
  localparam int IMPULSE_EXP = 40;
  localparam int DELTA_W     = IMPULSE_EXP + 2;

  // One restoring division step: returns {quotient bit, new remainder}.
  // The remainder entering the step is below the divisor unless the divisor is zero.
  function automatic logic [DEN_W:0] div_step(logic [DEN_W-1:0] rem,
                                              logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    t = {rem, 1'b0};
    if (t >= {1'b0, den}) begin
      div_step = {1'b1, DEN_W'(t - {1'b0, den})};
    end else begin
      div_step = {1'b0, t[DEN_W-1:0]};
    end
  endfunction

endpackage

FILE: src/particle_contact_resolver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_contact_resolver_core
// Resolves one particle contact per transaction: restitution impulse with
// resting-contact buildup removal, then penetration along the normal, split
// by mass ratio. Returns both velocities saturated per component.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one contact per transaction.
//   Output channel (out_valid / out_stall) returns both updated velocities.
//   The time_step register sits at byte address 0 of the APB port; the user
//   must write it only while no transaction is in flight (not enforced).
// Throughput: one contact per cycle while the output is not held by
//   out_stall. The datapath is an 8-stage pipeline; the mass split ratio
//   comes from a restoring divider spread over the first four stages,
//   17 quotient bits in total.
// Stall: when the output is held by out_stall the whole pipeline freezes
//   and in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset: synchronous, active low; clears all stage valid bits and loads
//   time_step with its default of 1092.
// ----------------------------------------------------------------------------
module particle_contact_resolver_core
  import prc_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int FRACTION_BITS   = FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [3*COMPONENT_WIDTH-1:0] in_first_velocity,
  input  logic [3*COMPONENT_WIDTH-1:0] in_second_velocity,
  input  logic [3*COMPONENT_WIDTH-1:0] in_first_acceleration,
  input  logic [3*COMPONENT_WIDTH-1:0] in_second_acceleration,
  input  logic [3*COMPONENT_WIDTH-1:0] in_contact_normal,
  input  logic [MASS_W-1:0]            in_first_mass,
  input  logic [MASS_W-1:0]            in_second_mass,
  input  logic                         in_first_finite,
  input  logic                         in_second_present,
  input  logic                         in_second_finite,
  input  logic [E_W-1:0]               in_restitution,
  input  logic [PEN_W-1:0]             in_penetration,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [3*COMPONENT_WIDTH-1:0] out_new_first_velocity,
  output logic [3*COMPONENT_WIDTH-1:0] out_new_second_velocity
);

  localparam int W    = COMPONENT_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int DW   = W + 1;
  localparam int PW   = 2 * W + 1;
  localparam int SW   = 2 * W + 3;
  localparam int TPW  = SW + TS_W + 1;
  localparam int BUW  = SW - F + 2;
  localparam int NVW  = SW + E_W + 2;
  localparam int EBW  = BUW + E_W + 1;
  localparam int VPW  = NVW + 1;
  localparam int MAGW = NVW + 3;
  localparam int MPW  = MAGW + W;
  localparam int PRW  = (MPW > DELTA_W + 1) ? MPW : DELTA_W + 1;
  localparam int RW   = RATIO_W + 1;
  localparam int DPW  = DELTA_W + RW;
  localparam int DAW  = DELTA_W + 1;
  localparam int FW   = DAW + 1;
  localparam int NST  = 8;
  localparam int NPL  = NST - 1;

  // Payload carried down the pipe.
  localparam int OFF_VA  = 0;
  localparam int OFF_VB  = 3 * W;
  localparam int OFF_N   = 6 * W;
  localparam int OFF_AF  = 9 * W;
  localparam int OFF_BF  = 9 * W + 1;
  localparam int OFF_E   = 9 * W + 2;
  localparam int OFF_PEN = OFF_E + E_W;
  localparam int PLW     = OFF_PEN + PEN_W;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [TS_W-1:0] ts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= TS_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_TIME_STEP)) begin
      ts_r <= pwdata[TS_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TIME_STEP) ? 32'(ts_r) : '0;

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic             advance;
  logic [NST-1:0]   v_r;
  logic [PLW-1:0]   pl_r [NPL];

  assign advance  = !(v_r[NST-1] && out_stall);
  assign in_stall = !advance;
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (advance) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  logic [PLW-1:0] pl_in;
  logic           bf_in;
  assign bf_in = in_second_present && in_second_finite;
  assign pl_in = {in_penetration, in_restitution, bf_in, in_first_finite,
                  in_contact_normal, in_second_velocity, in_first_velocity};

  always_ff @(posedge clk) begin
    if (advance) begin
      pl_r[0] <= pl_in;
      for (int k = 1; k < NPL; k++) begin
        pl_r[k] <= pl_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Mass ratio divider: quotient = (mb << 16) / (ma + mb), spread over stages
  // 0..3. Stage 0 resolves the top bit and DIV_STEPS more.
  // --------------------------------------------------------------------------
  logic [RATIO_W-1:0] q_r   [4];
  logic [DEN_W-1:0]   rem_r [4];
  logic [DEN_W-1:0]   den_r [4];
  logic               sz_r  [4];

  logic [RATIO_W-1:0] q0_nxt;
  logic [DEN_W-1:0]   rem0_nxt;
  logic [DEN_W-1:0]   den0;

  always_comb begin
    logic [DEN_W-1:0] mbx;
    logic [DEN_W:0]   st;
    den0 = {1'b0, in_first_mass} + {1'b0, in_second_mass};
    mbx  = {1'b0, in_second_mass};
    q0_nxt = '0;
    if (mbx >= den0) begin
      q0_nxt   = RATIO_W'(1);
      rem0_nxt = mbx - den0;
    end else begin
      rem0_nxt = mbx;
    end
    for (int s = 0; s < DIV_STEPS; s++) begin
      st       = div_step(rem0_nxt, den0);
      q0_nxt   = {q0_nxt[RATIO_W-2:0], st[DEN_W]};
      rem0_nxt = st[DEN_W-1:0];
    end
  end

  logic [RATIO_W-1:0] qk_nxt   [1:3];
  logic [DEN_W-1:0]   remk_nxt [1:3];

  always_comb begin
    logic [DEN_W:0] st;
    for (int k = 1; k < 4; k++) begin
      qk_nxt[k]   = q_r[k-1];
      remk_nxt[k] = rem_r[k-1];
      for (int s = 0; s < DIV_STEPS; s++) begin
        st          = div_step(remk_nxt[k], den_r[k-1]);
        qk_nxt[k]   = {qk_nxt[k][RATIO_W-2:0], st[DEN_W]};
        remk_nxt[k] = st[DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      q_r[0]   <= q0_nxt;
      rem_r[0] <= rem0_nxt;
      den_r[0] <= den0;
      sz_r[0]  <= (den0 == '0);
      for (int k = 1; k < 4; k++) begin
        q_r[k]   <= qk_nxt[k];
        rem_r[k] <= remk_nxt[k];
        den_r[k] <= den_r[k-1];
        sz_r[k]  <= sz_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: relative velocity and acceleration projected on the normal.
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] pv_r [3];
  logic signed [PW-1:0] pa_r [3];

  always_ff @(posedge clk) begin
    logic signed [W-1:0]  va, vb, aa, ab, n;
    logic signed [DW-1:0] vd, ad;
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        va = $signed(in_first_velocity[i*W +: W]);
        vb = $signed(in_second_velocity[i*W +: W]);
        aa = $signed(in_first_acceleration[i*W +: W]);
        ab = $signed(in_second_acceleration[i*W +: W]);
        n  = $signed(in_contact_normal[i*W +: W]);
        vd = in_second_present ? DW'(va) - DW'(vb) : DW'(va);
        ad = in_second_present ? DW'(aa) - DW'(ab) : DW'(aa);
        pv_r[i] <= PW'(vd) * PW'(n);
        pa_r[i] <= PW'(ad) * PW'(n);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: dot product sums.
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] vs2_r, acc2_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      vs2_r  <= SW'(pv_r[0]) + SW'(pv_r[1]) + SW'(pv_r[2]);
      acc2_r <= SW'(pa_r[0]) + SW'(pa_r[1]) + SW'(pa_r[2]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: separating velocity, buildup product, reflected velocity.
  // --------------------------------------------------------------------------
  logic signed [SW-1:0]  vs2s_r;
  logic signed [TPW-1:0] tp_r;
  logic signed [NVW-1:0] nv_r;

  always_ff @(posedge clk) begin
    logic signed [SW-1:0]  vs;
    logic signed [E_W:0]   e;
    if (advance) begin
      vs = vs2_r >>> F;
      e  = $signed({1'b0, pl_r[1][OFF_E +: E_W]});
      vs2s_r <= vs;
      tp_r   <= TPW'(acc2_r) * TPW'($signed({1'b0, ts_r}));
      nv_r   <= (-NVW'(vs)) * NVW'(e);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: scale the buildup by restitution.
  // --------------------------------------------------------------------------
  logic signed [SW-1:0]  vs3_r;
  logic signed [NVW-1:0] vsp0_r;
  logic signed [EBW-1:0] eb_r;
  logic                  buneg_r;

  always_ff @(posedge clk) begin
    logic signed [TPW-1:0] tsh;
    logic signed [BUW-1:0] bu;
    logic signed [E_W:0]   e;
    if (advance) begin
      tsh = tp_r >>> (F + TS_W);
      bu  = tsh[BUW-1:0];
      e   = $signed({1'b0, pl_r[2][OFF_E +: E_W]});
      vs3_r   <= vs2s_r;
      vsp0_r  <= nv_r >>> 8;
      eb_r    <= EBW'(bu) * EBW'(e);
      buneg_r <= bu[BUW-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: velocity change magnitude and split ratios.
  // --------------------------------------------------------------------------
  logic signed [MAGW-1:0] mag_r;
  logic signed [RW-1:0]   ra_r, rb_r;

  always_ff @(posedge clk) begin
    logic signed [EBW-1:0] ebs;
    logic signed [VPW-1:0] vsp;
    logic                  af, bf, act;
    logic [RATIO_W-1:0]    rbq;
    if (advance) begin
      ebs = eb_r >>> 8;
      vsp = VPW'(vsp0_r);
      if (buneg_r) begin
        vsp = vsp + VPW'(ebs);
        if (vsp[VPW-1]) begin
          vsp = '0;
        end
      end
      af  = pl_r[3][OFF_AF];
      bf  = pl_r[3][OFF_BF];
      // Only an approaching (or resting) contact with a finite body bounces.
      act = (af || bf) && (vs3_r[SW-1] || (vs3_r == '0));
      mag_r <= act ? MAGW'(vsp) - MAGW'(vs3_r) : '0;
      rbq = RATIO_ONE - q_r[3] - RATIO_W'(rem_r[3] != '0);
      if (sz_r[3]) begin
        ra_r <= $signed({1'b0, RATIO_HALF});
        rb_r <= $signed({1'b0, RATIO_HALF});
      end else begin
        ra_r <= $signed({1'b0, q_r[3]});
        rb_r <= $signed({1'b0, rbq});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: impulse and penetration components along the normal.
  // --------------------------------------------------------------------------
  function automatic logic signed [DELTA_W-1:0] clamp_d(logic signed [PRW-1:0] x);
    logic signed [PRW-1:0] lim;
    lim = PRW'(1) <<< IMPULSE_EXP;
    if (x > lim) begin
      clamp_d = DELTA_W'(lim);
    end else if (x < -lim) begin
      clamp_d = DELTA_W'(-lim);
    end else begin
      clamp_d = DELTA_W'(x);
    end
  endfunction

  logic signed [DELTA_W-1:0] dr_r [3];
  logic signed [DELTA_W-1:0] dp_r [3];
  logic signed [RW-1:0]      ra5_r, rb5_r;

  always_ff @(posedge clk) begin
    logic signed [W-1:0]   n;
    logic signed [PRW-1:0] pm, pp;
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        n  = $signed(pl_r[4][OFF_N + i*W +: W]);
        pm = (PRW'(mag_r) * PRW'(n)) >>> F;
        pp = (PRW'($signed({1'b0, pl_r[4][OFF_PEN +: PEN_W]})) * PRW'(n)) >>> F;
        dr_r[i] <= clamp_d(pm);
        dp_r[i] <= clamp_d(pp);
      end
      ra5_r <= ra_r;
      rb5_r <= rb_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: split the changes between the two particles.
  // --------------------------------------------------------------------------
  logic signed [DAW-1:0] da_r [3];
  logic signed [DAW-1:0] db_r [3];

  always_ff @(posedge clk) begin
    logic signed [DPW-1:0]     p;
    logic signed [DELTA_W-1:0] ar, ap, br, bp;
    logic                      af, bf;
    if (advance) begin
      af = pl_r[5][OFF_AF];
      bf = pl_r[5][OFF_BF];
      for (int i = 0; i < 3; i++) begin
        p  = (DPW'(dr_r[i]) * DPW'(ra5_r)) >>> 16;
        ar = p[DELTA_W-1:0];
        p  = (DPW'(dp_r[i]) * DPW'(ra5_r)) >>> 16;
        ap = p[DELTA_W-1:0];
        p  = (DPW'(dr_r[i]) * DPW'(rb5_r)) >>> 16;
        br = p[DELTA_W-1:0];
        p  = (DPW'(dp_r[i]) * DPW'(rb5_r)) >>> 16;
        bp = p[DELTA_W-1:0];
        if (!bf) begin
          da_r[i] <= DAW'(dr_r[i]) + DAW'(dp_r[i]);
          db_r[i] <= '0;
        end else if (!af) begin
          da_r[i] <= '0;
          db_r[i] <= DAW'(dr_r[i]) + DAW'(dp_r[i]);
        end else begin
          da_r[i] <= DAW'(ar) + DAW'(ap);
          db_r[i] <= DAW'(br) + DAW'(bp);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: apply, saturate and pack.
  // --------------------------------------------------------------------------
  function automatic logic [W-1:0] sat_w(logic signed [FW-1:0] x);
    logic signed [FW-1:0] hi, lo;
    hi = FW'((64'd1 << (W - 1)) - 64'd1);
    lo = -hi - FW'(1);
    if (x > hi) begin
      sat_w = hi[W-1:0];
    end else if (x < lo) begin
      sat_w = lo[W-1:0];
    end else begin
      sat_w = x[W-1:0];
    end
  endfunction

  logic [3*W-1:0] nfv_r, nsv_r;

  always_ff @(posedge clk) begin
    logic signed [W-1:0]  va, vb;
    logic signed [FW-1:0] fa, fb;
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        va = $signed(pl_r[6][OFF_VA + i*W +: W]);
        vb = $signed(pl_r[6][OFF_VB + i*W +: W]);
        fa = FW'(va) + FW'(da_r[i]);
        fb = FW'(vb) - FW'(db_r[i]);
        nfv_r[i*W +: W] <= sat_w(fa);
        nsv_r[i*W +: W] <= sat_w(fb);
      end
    end
  end

  assign out_new_first_velocity  = nfv_r;
  assign out_new_second_velocity = nsv_r;

endmodule

FILE: src/prc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks for the particle contact resolver, bound to the core.
// ----------------------------------------------------------------------------
module prc_checker
  import prc_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [ADDR_W-1:0]            paddr,
  input logic [31:0]                  pwdata,
  input logic [31:0]                  prdata,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [3*COMPONENT_WIDTH-1:0] out_new_first_velocity,
  input logic [3*COMPONENT_WIDTH-1:0] out_new_second_velocity
);

  // Nothing comes out in the cycle right after reset is released.
  a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
    else $error("out_valid high right after reset");

  // The pipeline only backs up when its last stage is held.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow a held output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_first_velocity)
      && $stable(out_new_second_velocity))
    else $error("held output transaction changed");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && (paddr == ADDR_TIME_STEP)
      ##1 (paddr == ADDR_TIME_STEP) |-> prdata[TS_W-1:0] == $past(pwdata[TS_W-1:0]))
    else $error("time_step readback mismatch");

endmodule

bind particle_contact_resolver_core prc_checker #(
  .COMPONENT_WIDTH(COMPONENT_WIDTH)
) u_prc_checker (.*);
